// File: design/crc16_frame_deframer_assert.svh
// ----------------------------------------------------------------------------
// crc16_frame_deframer assertion macros
// shared property forms for the deframer checks
// ----------------------------------------------------------------------------
`ifndef CRC16_FRAME_DEFRAMER_ASSERT_SVH
`define CRC16_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CFD_ASSERT_NOW(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define CFD_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// shared widths, register map and crc-16 byte update for the frame deframer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cfd_pkg;

	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 16;
	localparam int CRC_W   = 16;
	localparam int PDATA_W = 32;
	localparam int PADDR_W = 3;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [CRC_W-1:0]  crc_t;
	typedef logic [0:0]        reg_idx_t;

	// register map, index = paddr[2]
	localparam reg_idx_t REG_MAGIC    = 1'b0;
	localparam reg_idx_t REG_CRC_INIT = 1'b1;

	localparam byte_t MAGIC_RESET    = 8'hAA;
	localparam crc_t  CRC_INIT_RESET = 16'hFFFF;
	localparam crc_t  CRC_POLY       = 16'h1021;

	// one byte into the crc, msb first
	function automatic crc_t crc16_feed(input crc_t crc_in, input byte_t b);
		crc_t c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < BYTE_W; i++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: design/cfd_if.sv
// ----------------------------------------------------------------------------
// cfd_if
// valid/ready channels for received bytes and deframer results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cfd_in_if import cfd_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfd_out_if import cfd_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  kind;
	byte_t data_byte;
	byte_t frame_type;
	byte_t sequence_res;
	len_t  frame_len;
	logic  frame_ok;

	modport source (
		output valid, output kind, output data_byte, output frame_type,
		output sequence_res, output frame_len, output frame_ok,
		input ready
	);
	modport sink (
		input valid, input kind, input data_byte, input frame_type,
		input sequence_res, input frame_len, input frame_ok,
		output ready
	);
endinterface

`default_nettype wire

// File: design/crc16_frame_deframer.sv
// ----------------------------------------------------------------------------
// crc16_frame_deframer
// byte-serial frame deframer: magic hunt, xor-checked header, streamed
// payload and crc-16 (0x1021, msb first) check with a frame-end status word
// a result word is registered and valid in the cycle after the byte that causes it
// intake: one byte per cycle while the result register is empty or draining
// a held result word does not stop intake once the consumer takes it
// reset: hunting, registers back to magic 0xAA and crc init 0xFFFF, no word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "crc16_frame_deframer_assert.svh"

module crc16_frame_deframer import cfd_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	cfd_in_if.sink             rx,
	cfd_out_if.source          res,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire [PADDR_W-1:0]  paddr,
	input  wire [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam logic [1:0] PH_HUNT    = 2'd0;
	localparam logic [1:0] PH_HEADER  = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;
	localparam logic [1:0] PH_CHECK   = 2'd3;

	// config registers
	byte_t    magic_q;
	crc_t     crc_init_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;

	// frame state
	logic [1:0] phase_q, phase_d;
	len_t       cnt_q, cnt_d;
	byte_t      type_q, type_d;
	byte_t      seq_q, seq_d;
	len_t       len_q, len_d;
	byte_t      hchk_q, hchk_d;
	crc_t       crc_q, crc_d;
	byte_t      crc_low_q, crc_low_d;

	// result register
	logic  res_valid_q;
	logic  res_kind_q;
	byte_t res_data_q;
	logic  res_ok_q;

	logic  in_fire;
	logic  emit;
	logic  emit_kind;
	byte_t emit_data;
	logic  emit_ok;
	crc_t  crc_next;
	len_t  cnt_inc;
	byte_t b;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx)
			REG_MAGIC:    prdata = PDATA_W'(magic_q);
			REG_CRC_INIT: prdata = PDATA_W'(crc_init_q);
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q    <= MAGIC_RESET;
			crc_init_q <= CRC_INIT_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_MAGIC:    magic_q    <= pwdata[BYTE_W-1:0];
				REG_CRC_INIT: crc_init_q <= pwdata[CRC_W-1:0];
				default:      ;
			endcase
		end
	end

	// intake runs while the result register is empty or draining
	assign rx.ready = !res_valid_q || res.ready;
	assign in_fire  = rx.valid && rx.ready;
	assign b        = rx.rx_byte;
	assign crc_next = crc16_feed(crc_q, b);
	assign cnt_inc  = cnt_q + len_t'(1);

	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		type_d    = type_q;
		seq_d     = seq_q;
		len_d     = len_q;
		hchk_d    = hchk_q;
		crc_d     = crc_q;
		crc_low_d = crc_low_q;
		emit      = 1'b0;
		emit_kind = 1'b0;
		emit_data = '0;
		emit_ok   = 1'b0;
		unique case (phase_q)
			PH_HUNT: begin
				if (b == magic_q) begin
					phase_d = PH_HEADER;
					cnt_d   = '0;
					hchk_d  = magic_q;
					crc_d   = crc_init_q;
				end
			end
			PH_HEADER: begin
				crc_d = crc_next;
				if (cnt_q[2]) begin
					// fifth header byte is the check byte
					cnt_d = '0;
					if (hchk_q != b) begin
						phase_d = PH_HUNT;
					end else if (len_q != '0) begin
						phase_d = PH_PAYLOAD;
					end else begin
						phase_d = PH_CHECK;
					end
				end else begin
					case (cnt_q[1:0])
						2'd0:    type_d = b;
						2'd1:    seq_d  = b;
						2'd2:    len_d  = len_t'(b);
						default: len_d  = {b, len_q[BYTE_W-1:0]};
					endcase
					hchk_d = hchk_q ^ b;
					cnt_d  = cnt_inc;
				end
			end
			PH_PAYLOAD: begin
				crc_d     = crc_next;
				cnt_d     = cnt_inc;
				emit      = 1'b1;
				emit_data = b;
				if (cnt_inc == len_q) begin
					phase_d = PH_CHECK;
					cnt_d   = '0;
				end
			end
			PH_CHECK: begin
				if (cnt_q[0] == 1'b0) begin
					crc_low_d = b;
					cnt_d     = len_t'(1);
				end else begin
					cnt_d     = '0;
					phase_d   = PH_HUNT;
					emit      = 1'b1;
					emit_kind = 1'b1;
					emit_ok   = ({b, crc_low_q} == crc_q);
				end
			end
			default: phase_d = PH_HUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			cnt_q     <= '0;
			type_q    <= '0;
			seq_q     <= '0;
			len_q     <= '0;
			hchk_q    <= '0;
			crc_q     <= CRC_INIT_RESET;
			crc_low_q <= '0;
		end else if (in_fire) begin
			phase_q   <= phase_d;
			cnt_q     <= cnt_d;
			type_q    <= type_d;
			seq_q     <= seq_d;
			len_q     <= len_d;
			hchk_q    <= hchk_d;
			crc_q     <= crc_d;
			crc_low_q <= crc_low_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in_fire && emit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// header fields do not change while a frame emits, so take them live
	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			res_kind_q <= emit_kind;
			res_data_q <= emit_data;
			res_ok_q   <= emit_ok;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.kind         = res_kind_q;
	assign res.data_byte    = res_data_q;
	assign res.frame_type   = type_q;
	assign res.sequence_res = seq_q;
	assign res.frame_len    = len_q;
	assign res.frame_ok     = res_ok_q;

	`CFD_ASSERT_NEXT(a_crc_hi_ends_frame, clk, arst_n,
		in_fire && phase_q == PH_CHECK && cnt_q[0],
		res_valid_q && res_kind_q && phase_q == PH_HUNT,
		"second crc byte did not produce a frame-end word")

	`CFD_ASSERT_NEXT(a_hunt_is_silent, clk, arst_n,
		in_fire && phase_q == PH_HUNT,
		res_valid_q == $past(res_valid_q && !res.ready),
		"word produced while hunting")

	`CFD_ASSERT_NOW(a_payload_len_nonzero, clk, arst_n,
		phase_q == PH_PAYLOAD,
		len_q != '0 && cnt_q < len_q,
		"payload phase with count outside header length")

	`CFD_ASSERT_NOW(a_check_count, clk, arst_n,
		phase_q == PH_CHECK,
		cnt_q[LEN_W-1:1] == '0,
		"crc phase count beyond the two crc bytes")

	`CFD_ASSERT_NOW(a_frame_end_fields, clk, arst_n,
		res_valid_q && res_kind_q,
		res_data_q == '0,
		"frame-end word carries payload data")

endmodule

`default_nettype wire

// File: test/tb_cfd_pkg.sv
// ----------------------------------------------------------------------------
// tb_cfd_pkg
// result word layout and crc-16 byte update shared by the deframer testbench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tb_cfd_pkg;
	import cfd_pkg::*;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	typedef struct packed {
		logic  kind;
		byte_t data_byte;
		byte_t frame_type;
		byte_t sequence_res;
		len_t  frame_len;
		logic  frame_ok;
	} deframe_word_t;

	// ccitt polynomial, msb first, one byte at a time
	function automatic crc_t crc_ccitt_byte(input crc_t acc, input byte_t b);
		crc_t c;
		c = acc ^ crc_t'({b, 8'h00});
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = (c << 1) ^ 16'h1021;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

// File: test/cfd_checker.sv
// ----------------------------------------------------------------------------
// cfd_checker
// watches the byte and result channels and the register port, predicts the
// deframer's result words and compares each one against the oldest due word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfd_checker import cfd_pkg::*, tb_cfd_pkg::*; (
	input  wire               clk,
	input  wire               arst_n,
	cfd_in_if                 rx,
	cfd_out_if                res,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire [PADDR_W-1:0] paddr,
	input  wire [PDATA_W-1:0] pwdata,
	input  wire [PDATA_W-1:0] prdata,
	input  wire               pready,
	output int                fail_count,
	output int                words_pending,
	output int                frames_good,
	output int                frames_bad,
	output int                payload_words
);

	typedef enum logic [1:0] {
		ST_HUNT,
		ST_HEADER,
		ST_PAYLOAD,
		ST_CRC
	} deframe_state_e;

	deframe_state_e st;
	len_t           cnt;
	byte_t          hdr_type;
	byte_t          hdr_seq;
	len_t           hdr_len;
	byte_t          hdr_xor;
	crc_t           crc_acc;
	byte_t          crc_lo;
	byte_t          cfg_magic;
	crc_t           cfg_init;

	deframe_word_t  due_words[$];
	int             n_fail;
	int             n_good;
	int             n_bad;
	int             n_payload;

	task automatic field_check(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			n_fail++;
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	task automatic push_word(input logic kind, input byte_t data, input logic ok);
		deframe_word_t w;
		w.kind         = kind;
		w.data_byte    = data;
		w.frame_type   = hdr_type;
		w.sequence_res = hdr_seq;
		w.frame_len    = hdr_len;
		w.frame_ok     = ok;
		due_words = {due_words, w};
	endtask

	task automatic deframe_step(input byte_t b);
		case (st)
			ST_HUNT: begin
				// config is latched at the start of each frame
				if (b == cfg_magic) begin
					st      = ST_HEADER;
					cnt     = '0;
					hdr_xor = cfg_magic;
					crc_acc = cfg_init;
				end
			end
			ST_HEADER: begin
				crc_acc = crc_ccitt_byte(crc_acc, b);
				if (cnt < 4) begin
					case (cnt)
						0: hdr_type = b;
						1: hdr_seq = b;
						2: hdr_len = {8'h00, b};
						default: hdr_len[15:8] = b;
					endcase
					hdr_xor ^= b;
					cnt++;
				end else begin
					cnt = '0;
					if (hdr_xor != b) begin
						st = ST_HUNT;
					end else begin
						st = (hdr_len != 0) ? ST_PAYLOAD : ST_CRC;
					end
				end
			end
			ST_PAYLOAD: begin
				crc_acc = crc_ccitt_byte(crc_acc, b);
				cnt++;
				if (cnt == hdr_len) begin
					st  = ST_CRC;
					cnt = '0;
				end
				push_word(KIND_PAYLOAD, b, 1'b0);
			end
			default: begin
				if (cnt == 0) begin
					crc_lo = b;
					cnt    = 1;
				end else begin
					cnt = '0;
					st  = ST_HUNT;
					push_word(KIND_END, 8'h00, {b, crc_lo} == crc_acc);
				end
			end
		endcase
	endtask

	task automatic check_word(input deframe_word_t got);
		deframe_word_t want;
		if (due_words.size() == 0) begin
			n_fail++;
			$display("%0t ns: result word with none due, got kind %0d data %0h", $time,
				got.kind, got.data_byte);
			return;
		end
		want = due_words.pop_front();
		field_check("kind", want.kind, got.kind);
		field_check("data_byte", want.data_byte, got.data_byte);
		field_check("frame_type", want.frame_type, got.frame_type);
		field_check("sequence_res", want.sequence_res, got.sequence_res);
		field_check("frame_len", want.frame_len, got.frame_len);
		field_check("frame_ok", want.frame_ok, got.frame_ok);
		if (got.kind === KIND_END) begin
			if (got.frame_ok === 1'b1) n_good++;
			else n_bad++;
		end else begin
			n_payload++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		deframe_word_t got;
		if (!arst_n) begin
			st        = ST_HUNT;
			cnt       = '0;
			hdr_type  = '0;
			hdr_seq   = '0;
			hdr_len   = '0;
			hdr_xor   = '0;
			crc_acc   = CRC_INIT_RESET;
			crc_lo    = '0;
			cfg_magic = MAGIC_RESET;
			cfg_init  = CRC_INIT_RESET;
			n_fail    = 0;
			n_good    = 0;
			n_bad     = 0;
			n_payload = 0;
			due_words.delete();
		end else begin
			// outputs first: a word never belongs to the byte taken on the same edge
			if (res.valid && res.ready) begin
				got.kind         = res.kind;
				got.data_byte    = res.data_byte;
				got.frame_type   = res.frame_type;
				got.sequence_res = res.sequence_res;
				got.frame_len    = res.frame_len;
				got.frame_ok     = res.frame_ok;
				check_word(got);
			end
			if (rx.valid && rx.ready) deframe_step(rx.rx_byte);
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_MAGIC) cfg_magic = pwdata[7:0];
					else cfg_init = pwdata[15:0];
				end else if (paddr[2] == REG_MAGIC) begin
					field_check("magic_byte readback", {8'h00, cfg_magic}, {8'h00, prdata[7:0]});
				end else begin
					field_check("crc_init readback", cfg_init, prdata[15:0]);
				end
			end
		end
		fail_count    <= n_fail;
		words_pending <= due_words.size();
		frames_good   <= n_good;
		frames_bad    <= n_bad;
		payload_words <= n_payload;
	end

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the crc-16 frame deframer: directed frames, then random
// well-formed, corrupted and truncated frames under several register
// settings, with bursty input and a stalling result consumer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import cfd_pkg::*;
	import tb_cfd_pkg::*;

	typedef enum int {
		RCV_OPEN,
		RCV_RANDOM,
		RCV_PERIODIC,
		RCV_BURSTY
	} rcv_mode_e;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int fail_count;
	int words_pending;
	int frames_good;
	int frames_bad;
	int payload_words;

	byte_t     tx_q[$];
	byte_t     cur_magic;
	crc_t      cur_init;
	int        burst_left;
	bit        idle_on;
	int        bytes_sent;
	rcv_mode_e rcv_mode = RCV_OPEN;
	int        rcv_left = 0;
	int        rcv_hold = 0;

	cfd_in_if  rx_if();
	cfd_out_if res_if();

	crc16_frame_deframer i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_if),
		.res     (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	cfd_checker i_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx            (rx_if),
		.res           (res_if),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.fail_count    (fail_count),
		.words_pending (words_pending),
		.frames_good   (frames_good),
		.frames_bad    (frames_bad),
		.payload_words (payload_words)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// result consumer switches between its own stall patterns
	always @(posedge clk) begin
		if (rcv_left == 0) begin
			rcv_mode = rcv_mode_e'($urandom_range(0, 3));
			rcv_left = $urandom_range(40, 300);
		end else begin
			rcv_left--;
		end
		case (rcv_mode)
			RCV_OPEN: res_if.ready <= 1'b1;
			RCV_RANDOM: res_if.ready <= ($urandom_range(0, 3) != 0);
			RCV_PERIODIC: res_if.ready <= ((rcv_left % 8) < 5);
			default: begin
				if (rcv_hold > 0) begin
					rcv_hold--;
					res_if.ready <= 1'b0;
				end else begin
					res_if.ready <= 1'b1;
					if ($urandom_range(0, 9) == 0) rcv_hold = $urandom_range(1, 30);
				end
			end
		endcase
	end

	task automatic reg_access(input bit wr, input reg_idx_t idx, input logic [PDATA_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// write, then read back
	task automatic set_reg(input reg_idx_t idx, input int unsigned v);
		reg_access(1'b1, idx, PDATA_W'(v));
		if (idx == REG_MAGIC) cur_magic = byte_t'(v);
		else cur_init = crc_t'(v);
		reg_access(1'b0, idx, '0);
	endtask

	task automatic send_byte(input byte_t b);
		int gap;
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		@(posedge clk);
		while (!rx_if.ready) @(posedge clk);
		bytes_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 3);
			if (idle_on && gap > 0) begin
				rx_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic flush_bytes();
		while (tx_q.size() > 0) send_byte(tx_q.pop_front());
	endtask

	// wait until every due word has come, with the byte input held idle
	task automatic settle();
		rx_if.valid <= 1'b0;
		@(posedge clk);
		while (words_pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic push_frame(input byte_t t, input byte_t s, input len_t n, input bit bad_hdr,
			input bit bad_crc);
		byte_t hdr[4];
		byte_t chk;
		byte_t p;
		crc_t  c;
		hdr = '{t, s, n[7:0], n[15:8]};
		chk = cur_magic ^ t ^ s ^ n[7:0] ^ n[15:8];
		if (bad_hdr) chk ^= byte_t'($urandom_range(1, 255));
		c = cur_init;
		tx_q = {tx_q, cur_magic};
		foreach (hdr[i]) begin
			tx_q = {tx_q, hdr[i]};
			c = crc_ccitt_byte(c, hdr[i]);
		end
		tx_q = {tx_q, chk};
		c = crc_ccitt_byte(c, chk);
		if (bad_hdr) return;
		for (int i = 0; i < int'(n); i++) begin
			p = byte_t'($urandom);
			tx_q = {tx_q, p};
			c = crc_ccitt_byte(c, p);
		end
		if (bad_crc) c ^= crc_t'($urandom_range(1, 65535));
		tx_q = {tx_q, c[7:0]};
		tx_q = {tx_q, c[15:8]};
	endtask

	task automatic random_traffic(input int n_bytes);
		int   budget;
		int   r;
		len_t n;
		budget = 0;
		while (budget < n_bytes) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				n = ($urandom_range(0, 9) == 0) ? len_t'(0) : len_t'($urandom_range(1, 12));
				push_frame(byte_t'($urandom), byte_t'($urandom), n, 1'b0,
					$urandom_range(0, 4) == 0);
			end else if (r < 80) begin
				push_frame(byte_t'($urandom), byte_t'($urandom), len_t'($urandom), 1'b1, 1'b0);
			end else if (r < 90) begin
				repeat ($urandom_range(1, 6)) tx_q = {tx_q, byte_t'($urandom)};
			end else begin
				// cut short: the next frame's bytes land in the wrong place
				push_frame(byte_t'($urandom), byte_t'($urandom), len_t'($urandom_range(0, 6)),
					1'b0, 1'b0);
				repeat ($urandom_range(1, 4)) begin
					if (tx_q.size() > 1) void'(tx_q.pop_back());
				end
			end
			budget += tx_q.size();
			flush_bytes();
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		rx_if.valid   <= 1'b0;
		rx_if.rx_byte <= '0;
		cur_magic  = MAGIC_RESET;
		cur_init   = CRC_INIT_RESET;
		burst_left = 0;
		bytes_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		reg_access(1'b0, REG_MAGIC, '0);
		reg_access(1'b0, REG_CRC_INIT, '0);

		// directed frames at reset values, back to back
		idle_on = 1'b0;
		push_frame(8'hFF, 8'h00, 16'h0000, 1'b0, 1'b0);
		push_frame(8'h00, 8'hFF, 16'hFFFF, 1'b1, 1'b0);
		push_frame(8'h5A, 8'h81, 16'h0001, 1'b0, 1'b1);
		flush_bytes();
		settle();

		idle_on = 1'b1;
		set_reg(REG_MAGIC, 32'h00);
		set_reg(REG_CRC_INIT, 32'h0000);
		random_traffic(40);
		settle();

		set_reg(REG_MAGIC, 32'hFF);
		set_reg(REG_CRC_INIT, 32'hFFFF);
		random_traffic(40);
		settle();

		set_reg(REG_MAGIC, $urandom_range(0, 255));
		set_reg(REG_CRC_INIT, $urandom_range(0, 65535));
		random_traffic(40);
		// leave a frame half-read while the registers change under it
		push_frame(byte_t'($urandom), byte_t'($urandom), 16'd5, 1'b0, 1'b0);
		repeat (4) send_byte(tx_q.pop_front());
		settle();
		set_reg(REG_MAGIC, $urandom_range(0, 255));
		set_reg(REG_CRC_INIT, $urandom_range(0, 65535));
		flush_bytes();
		random_traffic(10);
		push_frame(byte_t'($urandom), byte_t'($urandom), 16'd256, 1'b0, 1'b0);
		flush_bytes();
		random_traffic(15);
		settle();
		repeat (8) @(posedge clk);

		$display("run covered %0d received bytes over five register settings", bytes_sent);
		$display("frame ends: %0d crc good, %0d crc bad; %0d payload words", frames_good,
			frames_bad, payload_words);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
